// ===== hw/rtl/eeg_dfs_pkg.sv =====
// Shared types, constants and register indexes for the converter frame deframer and scaler.
// No dependencies; every module of the block imports this package.
`default_nettype none

package eeg_dfs_pkg;

   localparam int CHANNELS     = 8;
   localparam int STATUS_BYTES = 3;
   localparam int FRAME_LEN    = STATUS_BYTES + 3 * CHANNELS;
   localparam int POS_W        = 5;

   localparam int VREF_W = 23;
   localparam int GAIN_W = 5;
   localparam int CODE_W = 24;
   localparam int NV_W   = 34;
   localparam int PROD_W = CODE_W + VREF_W;
   localparam int NUM_W  = PROD_W + 10;
   localparam int DEN_W  = GAIN_W + VREF_W;
   localparam int CNT_W  = 6;

   localparam logic [VREF_W-1:0] FULL_SCALE = 23'd8388607;
   localparam logic [9:0]        NV_PER_UV  = 10'd1000;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 23;
   localparam logic [CSR_INDEX_W-1:0] REG_VREF = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN = 4'd1;
   localparam logic [VREF_W-1:0] VREF_RESET = 23'd4500000;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 5'd24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   typedef struct packed {
      logic [VREF_W-1:0] vref_microvolts;
      logic [GAIN_W-1:0] pga_gain;
   } cfg_type;

   typedef struct packed {
      logic               is_status;
      logic [2:0]         channel_index;
      logic [23:0]        status_word;
      logic signed [23:0] sample_code;
      logic               end_of_frame;
   } item_type;

   typedef struct packed {
      logic                   is_status;
      logic [2:0]             channel_index;
      logic [23:0]            status_word;
      logic signed [23:0]     sample_code;
      logic signed [NV_W-1:0] nanovolts;
      logic                   end_of_frame;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_VREF,
      S_MUL_NV,
      S_DIVIDE,
      S_SIGN,
      S_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/eeg_dfs_front.sv =====
// Front end: tracks the byte position in the frame and assembles status and sample words.
// Depends on eeg_dfs_pkg; pushes classified items into eeg_dfs_queue.
`default_nettype none

module eeg_dfs_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                frame_start,
   output logic                     push,
   output eeg_dfs_pkg::item_type    item
);
   import eeg_dfs_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in, pos_cur;
   logic [1:0]       sub_ff, sub_in, sub_cur;
   logic [2:0]       ch_ff, ch_in, ch_cur;
   logic [23:0]      status_ff, status_in;
   logic [15:0]      sample_ff, sample_in;
   logic             emit;

   always_comb begin
      pos_cur   = frame_start ? '0 : pos_ff;
      sub_cur   = frame_start ? '0 : sub_ff;
      ch_cur    = frame_start ? '0 : ch_ff;
      pos_in    = (pos_cur == POS_W'(FRAME_LEN - 1)) ? '0 : pos_cur + 1'b1;
      status_in = status_ff;
      sample_in = sample_ff;
      sub_in    = sub_cur;
      ch_in     = ch_cur;
      emit      = 1'b0;
      item      = '0;
      if (pos_cur < POS_W'(STATUS_BYTES)) begin
         status_in = (pos_cur == '0) ? {16'h0000, data_byte} : {status_ff[15:0], data_byte};
         sub_in    = '0;
         ch_in     = '0;
         emit      = (pos_cur == POS_W'(STATUS_BYTES - 1));
         item.is_status   = 1'b1;
         item.status_word = status_in;
      end else begin
         sample_in = (sub_cur == 2'd0) ? {8'h00, data_byte} : {sample_ff[7:0], data_byte};
         if (sub_cur == 2'd2) begin
            emit   = 1'b1;
            sub_in = '0;
            ch_in  = ch_cur + 1'b1;
         end else begin
            sub_in = sub_cur + 1'b1;
         end
         item.channel_index = ch_cur;
         item.sample_code   = {sample_ff, data_byte};
         item.end_of_frame  = (ch_cur == 3'(CHANNELS - 1));
      end
      push = accept && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         sub_ff    <= '0;
         ch_ff     <= '0;
         status_ff <= '0;
         sample_ff <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         sub_ff    <= sub_in;
         ch_ff     <= ch_in;
         status_ff <= status_in;
         sample_ff <= sample_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/eeg_dfs_queue.sv =====
// Short request queue between the front end and the scaler.
// Depends on eeg_dfs_pkg for the item type and depth.
`default_nettype none

module eeg_dfs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  eeg_dfs_pkg::item_type  push_item,
   input  wire logic              pop,
   output eeg_dfs_pkg::item_type  head_item,
   output logic                   empty,
   output logic                   full
);
   import eeg_dfs_pkg::*;

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/eeg_dfs_back.sv =====
// Back end: scales channel codes to nanovolts with two multiplies and a radix-2 divider,
// and holds each result in the output register. Depends on eeg_dfs_pkg.
`default_nettype none

module eeg_dfs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  eeg_dfs_pkg::cfg_type     cfg,
   input  eeg_dfs_pkg::item_type    head_item,
   input  wire logic                empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output eeg_dfs_pkg::result_type  rsp
);
   import eeg_dfs_pkg::*;

   back_state_type     state_ff, state_in;
   item_type           item_ff, item_in;
   logic [CODE_W-1:0]  mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NV_W-1:0]    nv_ff, nv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic               bypass, load;
   logic [DEN_W:0]     shifted;

   assign bypass = head_item.is_status || (cfg.pga_gain == '0) || (cfg.vref_microvolts == '0);
   assign load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign shifted = {rem_ff, num_ff[NUM_W-1]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (!empty) state_in = bypass ? S_DONE : S_MUL_VREF;
         S_MUL_VREF: state_in = S_MUL_NV;
         S_MUL_NV:   state_in = S_DIVIDE;
         S_DIVIDE:   if (cnt_ff == '0) state_in = S_SIGN;
         S_SIGN:     state_in = S_DONE;
         S_DONE:     if (load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pop     = 1'b0;
      item_in = item_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      nv_in   = nv_ff;
      unique case (state_ff)
         S_IDLE: begin
            pop     = !empty;
            item_in = head_item;
            neg_in  = head_item.sample_code[CODE_W-1];
            mag_in  = head_item.sample_code[CODE_W-1] ?
                      (~head_item.sample_code) + 1'b1 : head_item.sample_code;
            nv_in   = '0;
         end
         S_MUL_VREF: begin
            prod_in = PROD_W'(mag_ff) * PROD_W'(cfg.vref_microvolts);
            den_in  = DEN_W'(cfg.pga_gain) * DEN_W'(FULL_SCALE);
         end
         S_MUL_NV: begin
            num_in = NUM_W'(prod_ff) * NUM_W'(NV_PER_UV);
            rem_in = '0;
            cnt_in = CNT_W'(NUM_W - 1);
         end
         S_DIVIDE: begin
            if (shifted >= {1'b0, den_ff}) begin
               rem_in = DEN_W'(shifted - {1'b0, den_ff});
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
         end
         S_SIGN: begin
            nv_in = neg_ff ? (~num_ff[NV_W-1:0]) + 1'b1 : num_ff[NV_W-1:0];
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.is_status     = item_ff.is_status;
         rsp_in.channel_index = item_ff.channel_index;
         rsp_in.status_word   = item_ff.status_word;
         rsp_in.sample_code   = item_ff.sample_code;
         rsp_in.nanovolts     = nv_ff;
         rsp_in.end_of_frame  = item_ff.end_of_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      nv_ff   <= nv_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/eeg_adc_frame_deframer_scaler_core.sv =====
// Path: status or unscaled sample via queue, scaler item register and output register to
// rsp_tvalid; a scaled sample also via two multiply states, 57 divider steps and the sign fix.
// Throughput: one request byte per cycle while the 4-entry queue has room; the scaler pops no
// new item before the last result is loaded for output, so it sets the sustained sample rate.
// Reset: synchronous, active high; clears frame position, queue, scaler and output valid,
// and loads vref_microvolts = 4500000 and pga_gain = 24.
`default_nettype none

module eeg_adc_frame_deframer_scaler_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,  // data_byte
   input  wire logic                                 req_tuser,  // frame_start
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // channel_index[2:0], status_word[26:3], sample_code[50:27], nanovolts[84:51], zero[87:85]
   output logic [87:0]                               rsp_tdata,
   output logic                                      rsp_tuser,  // is_status
   output logic                                      rsp_tlast,  // end_of_frame
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [eeg_dfs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [eeg_dfs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import eeg_dfs_pkg::*;

   cfg_type     cfg_ff;
   item_type    push_item, head_item;
   result_type  rsp;
   logic        push, pop, empty, full, accept;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vref_microvolts <= VREF_RESET;
         cfg_ff.pga_gain        <= GAIN_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_VREF) begin
            cfg_ff.vref_microvolts <= csr_data[VREF_W-1:0];
         end else if (csr_index == REG_GAIN) begin
            cfg_ff.pga_gain <= csr_data[GAIN_W-1:0];
         end
      end
   end

   eeg_dfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_tdata),
      .frame_start (req_tuser),
      .push        (push),
      .item        (push_item)
   );

   eeg_dfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (empty),
      .full      (full)
   );

   eeg_dfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_item (head_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.nanovolts, rsp.sample_code, rsp.status_word,
                       rsp.channel_index};
   assign rsp_tuser = rsp.is_status;
   assign rsp_tlast = rsp.end_of_frame;

endmodule

`default_nettype wire
